FILE: design/mfc_pkg.sv
package mfc_pkg;

	// Pixel and window types
	typedef logic [7:0] pix_t;
	localparam int WIN_CELLS = 9;
	typedef logic [WIN_CELLS-1:0][7:0] win_t;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

	// Frame size after reset
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// Output position width
	localparam int POS_W = 11;

	// Results one pixel can complete, in delivery order
	localparam int RES_N = 4;
	localparam int RES_A = 0;   // (r-1, c-1)
	localparam int RES_B = 1;   // (r-1, c) at row end
	localparam int RES_C = 2;   // (r, c-1) in last row
	localparam int RES_D = 3;   // (r, c) at frame end

	// Centre cell of each result within the window
	localparam int CTR_A = 4;
	localparam int CTR_B = 5;
	localparam int CTR_C = 7;
	localparam int CTR_D = 8;

	// Window cells dropped at the image border
	localparam logic [WIN_CELLS-1:0] TOP_ROW_CELLS  = 9'b000_000_111;
	localparam logic [WIN_CELLS-1:0] LEFT_COL_CELLS = 9'b001_001_001;

	// Rank of the lower median for 9, 6 and 4 values
	localparam logic [3:0] RANK_FULL   = 4'd4;
	localparam logic [3:0] RANK_EDGE   = 4'd2;
	localparam logic [3:0] RANK_CORNER = 4'd1;

	// Border cropping of one result
	typedef struct packed {
		logic skip_row;
		logic skip_col;
	} crop_t;

endpackage

FILE: design/mfc_cfg.sv
module mfc_cfg
	import mfc_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	output logic [$clog2(MAX_WIDTH)-1:0]  col_last,
	output logic [$clog2(MAX_HEIGHT)-1:0] row_last,
	output logic                          clip,
	output logic                          restart
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int MW = (CW > RW) ? CW : RW;
	localparam int VW = ((CFG_DATA_W > MW + 1) ? CFG_DATA_W : MW + 1) + 1;
	localparam int RST_COL_LAST = ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;
	localparam int RST_ROW_LAST = ((RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT) - 1;

	logic [CW-1:0] col_last_q;
	logic [RW-1:0] row_last_q;
	logic          clip_q;
	logic [VW-1:0] data_x;
	logic [CW-1:0] col_last_d;
	logic [RW-1:0] row_last_d;

	// Clamp the written size to 3..max and keep the last index
	always_comb begin
		data_x = VW'(cfg_data);
		if (data_x < VW'(3))
			col_last_d = CW'(2);
		else if (data_x > VW'(MAX_WIDTH))
			col_last_d = CW'(MAX_WIDTH - 1);
		else
			col_last_d = CW'(data_x - VW'(1));
		if (data_x < VW'(3))
			row_last_d = RW'(2);
		else if (data_x > VW'(MAX_HEIGHT))
			row_last_d = RW'(MAX_HEIGHT - 1);
		else
			row_last_d = RW'(data_x - VW'(1));
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= CW'(RST_COL_LAST);
			row_last_q <= RW'(RST_ROW_LAST);
			clip_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  col_last_q <= col_last_d;
				CFG_HEIGHT: row_last_q <= row_last_d;
				CFG_MODE:   clip_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A size write restarts the frame
	assign restart  = cfg_valid && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);
	assign col_last = col_last_q;
	assign row_last = row_last_q;
	assign clip     = clip_q;

endmodule

FILE: design/mfc_line_buf.sv
module mfc_line_buf
	import mfc_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic                         bank_sel,
	input  logic [$clog2(MAX_WIDTH)-1:0] addr,
	input  pix_t                         wdata,
	output pix_t                         old_data,
	output pix_t                         prev_data
);

	pix_t bank0 [MAX_WIDTH];
	pix_t bank1 [MAX_WIDTH];
	pix_t rd0_s1;
	pix_t rd1_s1;
	logic sel_s1;

	// Read both rows at the column, overwrite the older one with the new pixel
	always_ff @(posedge clk) begin
		if (en) begin
			rd0_s1 <= bank0[addr];
			rd1_s1 <= bank1[addr];
			sel_s1 <= bank_sel;
			if (bank_sel)
				bank1[addr] <= wdata;
			else
				bank0[addr] <= wdata;
		end
	end

	// Two rows up comes from the written bank, one row up from the other
	assign old_data  = sel_s1 ? rd1_s1 : rd0_s1;
	assign prev_data = sel_s1 ? rd0_s1 : rd1_s1;

endmodule

FILE: design/mfc_median.sv
module mfc_median
	import mfc_pkg::*;
(
	input  win_t  win,
	input  crop_t crop,
	input  pix_t  centre,
	input  logic  clip,
	output pix_t  med
);

	logic [WIN_CELLS-1:0] mask;
	logic [3:0]           kth;
	logic [3:0]           rank [WIN_CELLS];
	pix_t                 pick;

	// Drop border cells and choose the lower-median rank
	always_comb begin
		mask = ~((crop.skip_row ? TOP_ROW_CELLS : '0) | (crop.skip_col ? LEFT_COL_CELLS : '0));
		if (crop.skip_row && crop.skip_col)
			kth = RANK_CORNER;
		else if (crop.skip_row || crop.skip_col)
			kth = RANK_EDGE;
		else
			kth = RANK_FULL;
	end

	// Rank each cell among the kept cells, ties broken by position
	always_comb begin
		for (int i = 0; i < WIN_CELLS; i++) begin
			rank[i] = 4'd0;
			for (int j = 0; j < WIN_CELLS; j++) begin
				if (mask[j] && (win[j] < win[i] || (win[j] == win[i] && j < i)))
					rank[i] = rank[i] + 4'd1;
			end
		end
	end

	// Select the cell holding the median rank, then clip
	always_comb begin
		pick = '0;
		for (int i = 0; i < WIN_CELLS; i++) begin
			if (mask[i] && rank[i] == kth)
				pick = win[i];
		end
		med = (clip && centre < pick) ? centre : pick;
	end

endmodule

FILE: design/median_filter_3x3_with_clip_top.sv
// Channel  Handshake               Payload                                        Dir
// in       in_valid / in_ready     pixel                                          in
// out      out_valid / out_ready   filtered_value, out_row, out_col, last_of_run  out
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data                            in
//
// One pixel can be accepted per cycle while the window stage is free; its results
// pass through stage 1, stage 2 and the output register. The window stage emits one
// result per cycle while the output register is free, so a pixel completing k results
// (0, 1, 2 or 4) holds that stage until its last is emitted, stalling the input when k > 1.
// The line buffer is read and written only at acceptance; cfg_ready is
// always high. Reset clears counters, valid flags and the pending result mask.
// A stalled output register stalls the window stage, then the input stage.
module median_filter_3x3_with_clip_top
	import mfc_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pix_t                  pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pix_t                  filtered_value,
	output logic [POS_W-1:0]      out_row,
	output logic [POS_W-1:0]      out_col,
	output logic                  last_of_run,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0] col_last;
	logic [RW-1:0] row_last;
	logic          clip;
	logic          restart;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          acc;

	logic             valid_s1;
	pix_t             px_s1;
	logic [RES_N-1:0] pend_s1;
	crop_t            crop_s1;
	logic [CW-1:0]    col_s1;
	logic [RW-1:0]    row_s1;
	pix_t             old_data;
	pix_t             prev_data;

	win_t             win_s2;
	logic [RES_N-1:0] pend_s2;
	crop_t            crop_s2;
	logic [CW-1:0]    col_s2;
	logic [RW-1:0]    row_s2;

	logic [RES_N-1:0] pick_oh;
	logic [RES_N-1:0] pend_left;
	logic             out_free;
	logic             emit;
	logic             s2_load;
	crop_t            sel_crop;
	pix_t             sel_centre;
	logic [POS_W-1:0] sel_row;
	logic [POS_W-1:0] sel_col;
	pix_t             med;

	logic             out_valid_q;
	pix_t             value_q;
	logic [POS_W-1:0] row_q_out;
	logic [POS_W-1:0] col_q_out;
	logic             last_q;

	mfc_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.col_last (col_last),
		.row_last (row_last),
		.clip     (clip),
		.restart  (restart)
	);

	assign cfg_ready = 1'b1;
	assign acc       = in_valid && in_ready;

	// Raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q == col_last) begin
				col_q <= '0;
				row_q <= (row_q == row_last) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	mfc_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.en       (acc),
		.bank_sel (row_q[0]),
		.addr     (col_q),
		.wdata    (pixel),
		.old_data (old_data),
		.prev_data(prev_data)
	);

	// Stage 1: pixel, position and the results it completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (acc)
			valid_s1 <= 1'b1;
		else if (s2_load)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1                <= pixel;
			col_s1               <= col_q;
			row_s1               <= row_q;
			crop_s1.skip_row     <= (row_q == RW'(1));
			crop_s1.skip_col     <= (col_q == CW'(1));
			pend_s1[RES_A]       <= (row_q != '0) && (col_q != '0);
			pend_s1[RES_B]       <= (row_q != '0) && (col_q != '0) && (col_q == col_last);
			pend_s1[RES_C]       <= (row_q != '0) && (col_q != '0) && (row_q == row_last);
			pend_s1[RES_D]       <= (row_q != '0) && (col_q != '0) && (col_q == col_last)
				&& (row_q == row_last);
		end
	end

	// Pick the earliest pending result and drop it once emitted
	assign pick_oh   = pend_s2 & (~pend_s2 + RES_N'(1));
	assign out_free  = !out_valid_q || out_ready;
	assign emit      = (pend_s2 != '0) && out_free;
	assign pend_left = emit ? (pend_s2 & ~pick_oh) : pend_s2;
	assign s2_load   = valid_s1 && (pend_left == '0);
	assign in_ready  = !valid_s1 || s2_load;

	// Stage 2: shift the window, hold it while results drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_s2 <= '0;
		else if (s2_load)
			pend_s2 <= pend_s1;
		else
			pend_s2 <= pend_left;
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			for (int i = 0; i < 3; i++) begin
				win_s2[i*3]     <= win_s2[i*3 + 1];
				win_s2[i*3 + 1] <= win_s2[i*3 + 2];
			end
			win_s2[2] <= old_data;
			win_s2[5] <= prev_data;
			win_s2[8] <= px_s1;
			crop_s2   <= crop_s1;
			col_s2    <= col_s1;
			row_s2    <= row_s1;
		end
	end

	// Crop, centre and position of the selected result
	always_comb begin
		if (pick_oh[RES_A]) begin
			sel_crop   = crop_s2;
			sel_centre = win_s2[CTR_A];
			sel_row    = POS_W'(row_s2 - RW'(1));
			sel_col    = POS_W'(col_s2 - CW'(1));
		end else if (pick_oh[RES_B]) begin
			sel_crop   = '{skip_row: crop_s2.skip_row, skip_col: 1'b1};
			sel_centre = win_s2[CTR_B];
			sel_row    = POS_W'(row_s2 - RW'(1));
			sel_col    = POS_W'(col_s2);
		end else if (pick_oh[RES_C]) begin
			sel_crop   = '{skip_row: 1'b1, skip_col: crop_s2.skip_col};
			sel_centre = win_s2[CTR_C];
			sel_row    = POS_W'(row_s2);
			sel_col    = POS_W'(col_s2 - CW'(1));
		end else begin
			sel_crop   = '{skip_row: 1'b1, skip_col: 1'b1};
			sel_centre = win_s2[CTR_D];
			sel_row    = POS_W'(row_s2);
			sel_col    = POS_W'(col_s2);
		end
	end

	mfc_median u_median (
		.win   (win_s2),
		.crop  (sel_crop),
		.centre(sel_centre),
		.clip  (clip),
		.med   (med)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q   <= med;
			row_q_out <= sel_row;
			col_q_out <= sel_col;
			last_q    <= (pend_left == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = value_q;
	assign out_row        = row_q_out;
	assign out_col        = col_q_out;
	assign last_of_run    = last_q;

`ifndef SYNTHESIS
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (col_q <= col_last) && (row_q <= row_last))
		else $error("raster position beyond configured frame");

	a_first_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (pend_s1 != '0) |-> pend_s1[RES_A])
		else $error("pixel completes results without its own position");

	a_corner_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pend_s1[RES_D] |-> pend_s1[RES_B] && pend_s1[RES_C])
		else $error("frame end result without row end and last row results");

	a_stage1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_load |=> valid_s1 && $stable(pend_s1) && $stable(px_s1))
		else $error("stage 1 item lost while window stage busy");
`endif

endmodule

FILE: verif/median_filter_3x3_with_clip_top_tb.sv
`timescale 1ns / 100ps

module median_filter_3x3_with_clip_top_tb
	import mfc_pkg::*;
;

	localparam int          LINE_MAX     = 2048;
	localparam int          ROW_MAX      = 2048;
	localparam int          WIN_DIM      = 3;
	localparam int          CLK_HALF_NS  = 4;
	localparam int          RESET_CYCLES = 11;
	localparam int          SETTLE_CYC   = 6;
	localparam int          END_WAIT_CYC = 20000;
	localparam realtime     LIMIT_NS     = 4_000_000.0;
	localparam int          MAX_PRINTS   = 30;
	localparam int          N_PHASES     = 18;
	localparam int          PHASES_PER_MODE = 6;
	localparam int          DIR_ROWS     = 23;

	// Register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Idle percentages per idling mode
	localparam int SEND_IDLE_LO = 27;
	localparam int SEND_IDLE_HI = 68;

	typedef enum logic {ST_PIX, ST_REG} stim_kind_e;

	typedef struct {
		stim_kind_e            kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		int unsigned           count;
		bit                    typed;
		pix_t                  typed_val;
	} stim_t;

	typedef struct {
		pix_t             value;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} result_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	pix_t                  pixel     = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	pix_t                  filtered_value;
	logic [POS_W-1:0]      out_row;
	logic [POS_W-1:0]      out_col;
	logic                  last_of_run;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Filter state mirrored by the predictor
	pix_t                  line_mem [2*LINE_MAX];
	pix_t                  win_cells [WIN_CELLS];
	int unsigned           cur_row;
	int unsigned           cur_col;
	logic [CFG_DATA_W-1:0] cfg_width;
	logic [CFG_DATA_W-1:0] cfg_height;
	logic                  filt_mode;

	result_t pending_results [$];
	int      n_errors   = 0;
	int      n_results  = 0;
	int      n_pixels   = 0;
	int      n_writes   = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	pix_t    tie_base = 8'd100;

	// Directed rows: pixel bursts and register writes
	stim_t dir_tab [DIR_ROWS] = '{
		// reset size is 640 wide: the first pixels complete nothing
		'{ST_PIX, CFG_WIDTH,  12'h000, 5,   1'b0, 8'h00},
		'{ST_REG, CFG_WIDTH,  12'd3,   1,   1'b0, 8'h00},
		// height still at its reset value: no last-row results
		'{ST_PIX, CFG_WIDTH,  12'h0FF, 9,   1'b1, 8'hFF},
		'{ST_REG, CFG_HEIGHT, 12'd3,   1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h000, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h0FF, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h080, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h001, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h0FE, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h07F, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h000, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h0FF, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h040, 1,   1'b0, 8'h00},
		// next frame follows with no write: counters wrap
		'{ST_PIX, CFG_WIDTH,  12'h0FF, 9,   1'b1, 8'hFF},
		'{ST_REG, CFG_MODE,   12'h001, 1,   1'b0, 8'h00},
		// unknown index must leave mode and sizes alone
		'{ST_REG, REG_SPARE,  12'hFFE, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h0C8, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h00A, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h05A, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h01E, 1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h0FA, 1,   1'b0, 8'h00},
		// size write in mid frame restarts at row 0, column 0
		'{ST_REG, CFG_WIDTH,  12'd4,   1,   1'b0, 8'h00},
		'{ST_PIX, CFG_WIDTH,  12'h0FF, 12,  1'b1, 8'hFF}
	};

	median_filter_3x3_with_clip_top #(
		.MAX_WIDTH  (LINE_MAX),
		.MAX_HEIGHT (ROW_MAX)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel          (pixel),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_value (filtered_value),
		.out_row        (out_row),
		.out_col        (out_col),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#(LIMIT_NS);
		$display("median_filter_3x3_with_clip_top_tb: FAIL");
		$finish;
	end

	function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
			input int unsigned maxv);
		if (v < WIN_DIM) return WIN_DIM;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// Lower median of the window cells from row top and column left onward
	function automatic pix_t window_pick(input int top, input int left, input int ctr);
		pix_t vals [WIN_CELLS];
		pix_t v;
		pix_t med;
		int   n;
		int   k;
		n = 0;
		for (int i = top; i < WIN_DIM; i++) begin
			for (int j = left; j < WIN_DIM; j++) begin
				v = win_cells[i * WIN_DIM + j];
				k = n;
				while (k > 0 && vals[k - 1] > v) begin
					vals[k] = vals[k - 1];
					k--;
				end
				vals[k] = v;
				n++;
			end
		end
		med = vals[(n - 1) / 2];
		// clip mode: never exceed the centre pixel
		if (filt_mode && win_cells[ctr] < med) med = win_cells[ctr];
		return med;
	endfunction

	function automatic result_t make_result(input pix_t v, input int unsigned r,
			input int unsigned c);
		result_t res;
		res.value = v;
		res.row   = POS_W'(r);
		res.col   = POS_W'(c);
		res.last  = 1'b0;
		return res;
	endfunction

	// Advance the filter by one pixel and queue the positions it completes
	function automatic void filter_step(input pix_t px, input bit typed, input pix_t typed_val);
		result_t     outs [RES_N];
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned old_slot;
		int unsigned prev_slot;
		int          n;
		int          top;
		int          left;
		bit          row_end;
		bit          last_row;
		w = clamp_dim(cfg_width, LINE_MAX);
		h = clamp_dim(cfg_height, ROW_MAX);
		r = cur_row;
		c = cur_col;
		if (r >= h || c >= w) begin
			r = 0;
			c = 0;
		end
		old_slot  = (r % 2) * LINE_MAX + c;
		prev_slot = ((r + 1) % 2) * LINE_MAX + c;

		// shift the window left, bring in the new column
		for (int i = 0; i < WIN_DIM; i++) begin
			win_cells[i * WIN_DIM]     = win_cells[i * WIN_DIM + 1];
			win_cells[i * WIN_DIM + 1] = win_cells[i * WIN_DIM + 2];
		end
		win_cells[2] = line_mem[old_slot];
		win_cells[5] = line_mem[prev_slot];
		win_cells[8] = px;
		line_mem[old_slot] = px;

		row_end  = (c == w - 1);
		last_row = (r == h - 1);
		n = 0;
		if (r >= 1 && c >= 1) begin
			top  = (r >= 2) ? 0 : 1;
			left = (c >= 2) ? 0 : 1;
			outs[n] = make_result(window_pick(top, left, CTR_A), r - 1, c - 1);
			n++;
			if (row_end) begin
				outs[n] = make_result(window_pick(top, 1, CTR_B), r - 1, c);
				n++;
			end
			if (last_row) begin
				outs[n] = make_result(window_pick(1, left, CTR_C), r, c - 1);
				n++;
				if (row_end) begin
					outs[n] = make_result(window_pick(1, 1, CTR_D), r, c);
					n++;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			if (typed) outs[k].value = typed_val;
			outs[k].last = (k == n - 1);
			pending_results.push_back(outs[k]);
		end

		// advance raster position, wrap at frame end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		cur_row = r;
		cur_col = c;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_WIDTH: begin
				cfg_width = data;
				cur_row   = 0;
				cur_col   = 0;
			end
			CFG_HEIGHT: begin
				cfg_height = data;
				cur_row    = 0;
				cur_col    = 0;
			end
			CFG_MODE: filt_mode = data[0];
			default: ;
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (n_errors < MAX_PRINTS)
			$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		n_errors++;
	endtask

	task automatic set_idling(input int mode_sel);
		case (mode_sel)
			0: begin
				send_idle_pct = SEND_IDLE_LO;
				recv_idle_pct = SEND_IDLE_HI;
			end
			1: begin
				send_idle_pct = SEND_IDLE_HI;
				recv_idle_pct = SEND_IDLE_LO;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Drain, let the pipeline settle, then write one register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_reg(idx, data);
		n_writes++;
	endtask

	// Offer one pixel beat, with a random gap in front of it
	task automatic push_pixel(input pix_t v, input bit typed, input pix_t typed_val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= v;
		do @(posedge clk); while (!in_ready);
		filter_step(v, typed, typed_val);
		n_pixels++;
	endtask

	// Mix of full-range values, extremes and near-ties
	function automatic pix_t draw_pixel();
		int unsigned sel;
		sel = $urandom_range(3);
		case (sel)
			0: return $urandom_range(1) ? 8'hFF : 8'h00;
			1: return pix_t'(tie_base + $urandom_range(3));
			default: return pix_t'($urandom_range(255));
		endcase
	endfunction

	task automatic run_phase(input int p);
		logic [CFG_DATA_W-1:0] w_val;
		logic [CFG_DATA_W-1:0] h_val;
		logic                  m_val;
		int unsigned           frame_px;
		int unsigned           n_px;
		case (p)
			0: begin
				w_val = 12'd0;
				h_val = 12'd1;
				m_val = 1'b1;
			end
			1: begin
				w_val = 12'd2;
				h_val = 12'd0;
				m_val = 1'b0;
			end
			2: begin
				w_val = 12'hFFF;
				h_val = 12'd3;
				m_val = 1'($urandom_range(1));
			end
			8: begin
				w_val = 12'd3;
				h_val = 12'hFFF;
				m_val = 1'b1;
			end
			14: begin
				w_val = 12'd2048;
				h_val = 12'd3;
				m_val = 1'b0;
			end
			default: begin
				w_val = ($urandom_range(4) == 0) ? 12'($urandom_range(2))
					: 12'($urandom_range(6, 3));
				h_val = ($urandom_range(4) == 0) ? 12'($urandom_range(2))
					: 12'($urandom_range(4, 3));
				m_val = 1'($urandom_range(1));
			end
		endcase
		frame_px = clamp_dim(w_val, LINE_MAX) * clamp_dim(h_val, ROW_MAX);
		// large frames are only started; small ones run one frame plus a partial one
		if (frame_px > 64)
			n_px = 16 + $urandom_range(8);
		else
			n_px = frame_px + $urandom_range(frame_px - 1);
		tie_base = pix_t'($urandom_range(252));

		write_reg(CFG_WIDTH, w_val);
		write_reg(CFG_HEIGHT, h_val);
		if ($urandom_range(2) == 0) write_reg(REG_SPARE, 12'($urandom_range(4095)));
		write_reg(CFG_MODE, {11'($urandom_range(2047)), m_val});
		repeat (n_px) push_pixel(draw_pixel(), 1'b0, 8'h00);
	endtask

	// Receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each delivered beat with the oldest expected result
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result at (%0d,%0d) with nothing pending",
					out_row, out_col), filtered_value, 0);
			end else begin
				want = pending_results.pop_front();
				if (filtered_value !== want.value)
					flag_mismatch($sformatf("filtered_value at (%0d,%0d)", want.row, want.col),
						filtered_value, want.value);
				if (out_row !== want.row)
					flag_mismatch($sformatf("out_row at (%0d,%0d)", want.row, want.col),
						out_row, want.row);
				if (out_col !== want.col)
					flag_mismatch($sformatf("out_col at (%0d,%0d)", want.row, want.col),
						out_col, want.col);
				if (last_of_run !== want.last)
					flag_mismatch($sformatf("last_of_run at (%0d,%0d)", want.row, want.col),
						last_of_run, want.last);
			end
		end
	end

	initial begin
		// predictor starts from the reset state
		foreach (line_mem[i]) line_mem[i] = '0;
		foreach (win_cells[i]) win_cells[i] = '0;
		cur_row    = 0;
		cur_col    = 0;
		cfg_width  = CFG_DATA_W'(RESET_WIDTH);
		cfg_height = CFG_DATA_W'(RESET_HEIGHT);
		filt_mode  = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		set_idling(0);
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ST_REG)
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			else
				repeat (dir_tab[i].count)
					push_pixel(dir_tab[i].data[7:0], dir_tab[i].typed, dir_tab[i].typed_val);
		end

		// random frames, idling mode changes every few phases
		for (int p = 0; p < N_PHASES; p++) begin
			set_idling(p / PHASES_PER_MODE);
			run_phase(p);
		end
		in_valid <= 1'b0;

		// drain, then watch for strays
		for (int k = 0; k < END_WAIT_CYC && pending_results.size() != 0; k++)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("results never delivered", pending_results.size(), 0);

		$display("Covered %0d pixels and %0d checked results over %0d register writes,",
			n_pixels, n_results, n_writes);
		$display("small frames run through, sizes clamped up to 2048 started, both modes.");
		if (n_errors == 0) begin
			$display("median_filter_3x3_with_clip_top_tb: PASS");
		end else begin
			$display("median_filter_3x3_with_clip_top_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
design/mfc_pkg.sv
design/mfc_cfg.sv
design/mfc_line_buf.sv
design/mfc_median.sv
design/median_filter_3x3_with_clip_top.sv
verif/median_filter_3x3_with_clip_top_tb.sv
